[rtl/core/slid_pkg.sv]
`default_nettype none

package slid_pkg;

  // Default number of stored entries.
  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUMP     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture the input item
    logic    rd_below;   // read the entry just below the insert slot
    logic    rd_idx;     // read the entry at the scan index
    logic    ins_step;   // move the read entry up into the insert slot
    logic    ins_place;  // write the operand into the insert slot
    logic    del_keep;   // compact the read entry down, advance
    logic    del_drop;   // drop the read entry, advance
    logic    del_done;   // commit the compacted count
    logic    dmp_next;   // advance the dump index
    logic    emit;       // load the result register
    status_t emit_status;
  } slid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_end;
    logic idx_last;
    logic key_ge;
    logic match;
    logic found;
    logic out_free;
  } slid_stat_t;

endpackage

`default_nettype wire

[rtl/core/slid_ram.sv]
`default_nettype none

module slid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // Read data holds until the next read.
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/slid_ctrl.sv]
`default_nettype none

module slid_ctrl
  import slid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  output logic            in_ready,
  input  wire slid_stat_t stat,
  output slid_cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_START   = 8'b0000_0010,
    S_INS_RD  = 8'b0000_0100,
    S_INS_CMP = 8'b0000_1000,
    S_DEL_RD  = 8'b0001_0000,
    S_DEL_CMP = 8'b0010_0000,
    S_DMP_RD  = 8'b0100_0000,
    S_DMP_OUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_status = ST_INSERTED;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (!stat.full) begin
              state_nxt = S_INS_RD;
            end else if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_FULL;
              state_nxt       = S_IDLE;
            end
          end
          OP_DELETE: state_nxt = S_DEL_RD;
          OP_DUMP: begin
            if (!stat.empty) begin
              state_nxt = S_DMP_RD;
            end else if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_nxt       = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_RD: begin
        if (!stat.idx_zero) begin
          cmd.rd_below = 1'b1;
          state_nxt    = S_INS_CMP;
        end else if (stat.out_free) begin
          cmd.ins_place   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_INSERTED;
          state_nxt       = S_IDLE;
        end
      end
      S_INS_CMP: begin
        // Entries not below the operand move up one slot.
        if (stat.key_ge) begin
          cmd.ins_step = 1'b1;
          state_nxt    = S_INS_RD;
        end else if (stat.out_free) begin
          cmd.ins_place   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_INSERTED;
          state_nxt       = S_IDLE;
        end
      end
      S_DEL_RD: begin
        if (!stat.idx_end) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_DEL_CMP;
        end else if (stat.out_free) begin
          cmd.del_done    = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = stat.found ? ST_DELETED : ST_NOTFOUND;
          state_nxt       = S_IDLE;
        end
      end
      S_DEL_CMP: begin
        if (stat.match) begin
          cmd.del_drop = 1'b1;
        end else begin
          cmd.del_keep = 1'b1;
        end
        state_nxt = S_DEL_RD;
      end
      S_DMP_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_DUMP;
          cmd.dmp_next    = 1'b1;
          state_nxt       = stat.idx_last ? S_IDLE : S_DMP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/slid_dpath.sv]
`default_nettype none

module slid_dpath
  import slid_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire op_t                     in_op,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire slid_cmd_t               cmd,
  output slid_stat_t                   stat,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output status_t                      out_status,
  output logic signed [VAL_W-1:0]      out_value,
  output logic        [COUNT_W-1:0]    out_count,
  output logic                         out_last
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  op_t                     op_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        kept_r;
  logic                    found_r;
  logic [CNT_W-1:0]        total_r, total_nxt;
  logic [CNT_W-1:0]        idx_dec, idx_inc;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic                    out_last_r;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic             is_last;

  slid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign idx_dec = idx_r - CNT_W'(1);
  assign idx_inc = idx_r + CNT_W'(1);
  assign is_last = (idx_inc == total_r);

  // Memory port steering.
  always_comb begin
    ram_re    = cmd.rd_below | cmd.rd_idx;
    ram_raddr = cmd.rd_below ? idx_dec[AW-1:0] : idx_r[AW-1:0];
    ram_we    = cmd.ins_step | cmd.ins_place | cmd.del_keep;
    ram_waddr = cmd.del_keep ? kept_r[AW-1:0] : idx_r[AW-1:0];
    ram_wdata = cmd.ins_place ? val_r : ram_rdata;
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.ins_place) begin
      total_nxt = total_r + CNT_W'(1);
    end else if (cmd.del_done) begin
      total_nxt = kept_r;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = (in_op == OP_INSERT) ? total_r : '0;
    end else if (cmd.ins_step) begin
      idx_nxt = idx_dec;
    end else if (cmd.del_keep || cmd.del_drop || cmd.dmp_next) begin
      idx_nxt = idx_inc;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, total_nxt};

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r    <= in_op;
      val_r   <= in_value;
      kept_r  <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.del_keep) begin
        kept_r <= kept_r + CNT_W'(1);
      end
      if (cmd.del_drop) begin
        found_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_value_r  <= (cmd.emit_status == ST_DUMP) ? $signed(ram_rdata) : '0;
      out_count_r  <= count_ext[COUNT_W-1:0];
      out_last_r   <= (cmd.emit_status != ST_DUMP) || is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.full     = (total_r == CNT_W'(CAPACITY));
    stat.empty    = (total_r == '0);
    stat.idx_zero = (idx_r == '0);
    stat.idx_end  = (idx_r == total_r);
    stat.idx_last = is_last;
    stat.key_ge   = ($signed(ram_rdata) >= val_r);
    stat.match    = (ram_rdata == val_r);
    stat.found    = found_r;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

[rtl/core/sorted_list_insert_delete.sv]
// Sorted list store. Holds up to CAPACITY signed 32-bit values in ascending
// order in a single-port-write, registered-read RAM.
// The input channel carries one command item: in_tuser holds the operation
// (insert, delete all equal, dump) and in_tdata the operand. The result
// channel carries status in out_tuser, the entry value and entry count in
// out_tdata, and out_tlast marks the final result of each command.
// An insert walks down from the top of the list: each step reads the entry
// below the insert slot, compares it and, if it is not below the operand,
// moves it up one slot; at a smaller entry or at the bottom the operand is
// written. A delete compacts the whole list, keeping every entry that does
// not match. A dump gives one result per stored entry.
// A full insert, an empty dump and an unused operation do not touch the RAM.
// Each entry visited takes one RAM read, and the read data is
// registered before the compare. Commands are handled one at a time; a new
// item is accepted as soon as the last result of the previous one sits in
// the output register, even if the receiver has not yet taken it.
// Reset empties the list; the RAM contents need no clearing. When the
// receiver stalls, the result register holds its item and the sequence
// pauses until it is taken.
`default_nettype none

module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand_value
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] entry_value, [36:32] entry_count
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast
);

  slid_cmd_t               cmd;
  slid_stat_t              stat;
  logic                    in_fire;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_value;
  logic [COUNT_W-1:0]      res_count;

  // An item is taken only while the controller waits for a new command.
  assign in_fire = in_tvalid & in_tready;

  slid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slid_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (op_t'(in_tuser)),
    .in_value   ($signed(in_tdata)),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_value  (res_value),
    .out_count  (res_count),
    .out_last   (out_tlast)
  );

  // Pack the result fields; the top three bits pad to a whole byte.
  assign out_tdata = {3'b000, res_count, res_value};
  assign out_tuser = res_status;

endmodule

`default_nettype wire
